// ===== rtl/core/atcp_pkg.sv =====
// ----------------------------------------------------------------------------
// atcp_pkg - shared types and helpers for the at time command parser
// payload structs, result codes, head name lookup, digit packing, date check
// ----------------------------------------------------------------------------
package atcp_pkg;

   localparam int unsigned TimeWidth = 49;

   // result status codes
   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_NO_COLON    = 3'd1;
   localparam logic [2:0] STATUS_UNKNOWN     = 3'd2;
   localparam logic [2:0] STATUS_BAD_DATE    = 3'd3;
   localparam logic [2:0] STATUS_NO_END_TIME = 3'd4;

   // command kinds
   localparam logic [1:0] KIND_SETTIME  = 2'd0;
   localparam logic [1:0] KIND_START    = 2'd1;
   localparam logic [1:0] KIND_READDATA = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   // head table index, also the bit in the match flags
   localparam logic [1:0] HEAD_SETTIME  = 2'd0;
   localparam logic [1:0] HEAD_START    = 2'd1;
   localparam logic [1:0] HEAD_READDATA = 2'd2;

   localparam logic [3:0] SETTIME_LEN  = 4'd10;
   localparam logic [3:0] START_LEN    = 4'd8;
   localparam logic [3:0] READDATA_LEN = 4'd11;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_COMMA = 8'h2c;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [13:0] YEAR_MAX = 14'd2050;
   localparam logic [13:0] YEAR_MIN = 14'd1976;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [1:0]           command_kind;
      logic [TimeWidth-1:0] first_time;
      logic [TimeWidth-1:0] second_time;
   } rsp_payload_type;

   function automatic logic [3:0] head_len(logic [1:0] k);
      logic [3:0] len;
      case (k)
         HEAD_SETTIME:  len = SETTIME_LEN;
         HEAD_START:    len = START_LEN;
         HEAD_READDATA: len = READDATA_LEN;
         default:       len = 4'd0;
      endcase
      return len;
   endfunction

   // character idx of head name k, names left-aligned in 12 bytes
   function automatic logic [7:0] head_char(logic [1:0] k, logic [3:0] idx);
      logic [95:0] name;
      logic [6:0]  sh;
      logic [7:0]  ch;
      case (k)
         HEAD_SETTIME:  name = {"AT+SETTIME", 16'h0};
         HEAD_START:    name = {"AT+START", 32'h0};
         HEAD_READDATA: name = {"AT+READDATA", 8'h0};
         default:       name = '0;
      endcase
      sh = 7'(8'd88 - {idx, 3'b000});
      if (idx > 4'd11) begin
         ch = 8'h00;
      end else begin
         ch = name[sh +: 8];
      end
      return ch;
   endfunction

   // fold one decimal digit into the packed time at its fixed offset
   function automatic logic [TimeWidth-1:0] add_digit(logic [TimeWidth-1:0] acc,
                                                      logic [7:0] b,
                                                      logic [7:0] pos,
                                                      logic [7:0] origin);
      logic [TimeWidth-1:0] res;
      logic [7:0]           off;
      logic [2:0]           fld;
      logic [3:0]           dig;
      logic [17:0]          wide;
      logic [10:0]          narrow;
      res    = acc;
      off    = pos - origin;
      dig    = 4'(b - CHAR_ZERO);
      wide   = 18'(acc[48:35]) * 18'd10 + 18'(dig);
      narrow = '0;
      fld    = (off < 8'd4) ? 3'd0 : 3'(off[3:1] - 3'd1);
      if (b >= CHAR_ZERO && b <= CHAR_NINE && pos != 8'hff && pos >= origin
          && off <= 8'd13) begin
         case (fld)
            3'd0: res[48:35] = wide[13:0];
            3'd1: begin
               narrow     = 11'(acc[34:28]) * 11'd10 + 11'(dig);
               res[34:28] = narrow[6:0];
            end
            3'd2: begin
               narrow     = 11'(acc[27:21]) * 11'd10 + 11'(dig);
               res[27:21] = narrow[6:0];
            end
            3'd3: begin
               narrow     = 11'(acc[20:14]) * 11'd10 + 11'(dig);
               res[20:14] = narrow[6:0];
            end
            3'd4: begin
               narrow    = 11'(acc[13:7]) * 11'd10 + 11'(dig);
               res[13:7] = narrow[6:0];
            end
            3'd5: begin
               narrow   = 11'(acc[6:0]) * 11'd10 + 11'(dig);
               res[6:0] = narrow[6:0];
            end
            default: res = acc;
         endcase
      end
      return res;
   endfunction

   // set time plausibility, seconds unchecked, february fixed at 28
   function automatic logic date_bad(logic [TimeWidth-1:0] t);
      logic [6:0] lim;
      logic       bad;
      case (t[34:28]) inside
         7'd2:                      lim = 7'd28;
         7'd4, 7'd6, 7'd9, 7'd11:   lim = 7'd30;
         default:                   lim = 7'd31;
      endcase
      bad = (t[48:35] >= YEAR_MAX) || (t[48:35] <= YEAR_MIN)
         || (t[34:28] > 7'd12) || (t[34:28] == 7'd0)
         || (t[27:21] > lim) || (t[20:14] > 7'd23) || (t[13:7] > 7'd59);
      return bad;
   endfunction

endpackage

// ===== rtl/core/at_time_command_parser.sv =====
// ----------------------------------------------------------------------------
// at_time_command_parser - byte-wise parser for AT time commands
// one message byte per transfer in, one result per message out
// ----------------------------------------------------------------------------
// req channel: one message byte per transfer, last_byte marks the final byte;
//   head, colon, ignored part and the comma-separated YYYYMMDDhhmmss fields
// rsp channel: one transfer per message with status, recognised command and
//   the packed set / start and end times
// timing: a byte is parsed from the input register; the parse of a last byte
//   also loads its result into the output register, from which it transfers
// throughput: one byte per cycle unless a last byte waits on a stalled result;
//   the parse is a handful of compares, a multiply by ten, a 14-bit range check
// reset: synchronous, active high; parser back in the head phase, all
//   accumulators clear, both registers empty
// stall: a stalled result holds in the output register while bytes that make
//   no result keep flowing; only a last byte waits for the output register
//   to free up, and req_stall follows from that
// ----------------------------------------------------------------------------
module at_time_command_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  atcp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output atcp_pkg::rsp_payload_type rsp_payload
);
   import atcp_pkg::*;

   // parse phases
   localparam logic [2:0] PH_HEAD  = 3'd0;
   localparam logic [2:0] PH_MAC   = 3'd1;
   localparam logic [2:0] PH_SET   = 3'd2;
   localparam logic [2:0] PH_BEGIN = 3'd3;
   localparam logic [2:0] PH_END   = 3'd4;
   localparam logic [2:0] PH_ERR   = 3'd5;

   // input register
   logic            req_full_ff, req_full_in;
   req_payload_type req_data_ff;

   // parser state
   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           pos_ff, pos_in;
   logic [7:0]           origin_ff, origin_in;
   logic [2:0]           flags_ff, flags_in;
   logic [3:0]           count_ff, count_in;
   logic [TimeWidth-1:0] t1_ff, t1_in;
   logic [TimeWidth-1:0] t2_ff, t2_in;
   logic [2:0]           err_ff, err_in;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type result;

   logic       fire;
   logic [7:0] b;
   logic       last;
   logic [7:0] next_origin;

   assign b    = req_data_ff.data_byte;
   assign last = req_data_ff.last_byte;

   // a byte without a result never waits on the output side
   assign fire = req_full_ff && (!last || !rsp_valid_ff || !rsp_stall);

   assign req_stall   = req_full_ff && !fire;
   assign req_full_in = (req_valid && !req_stall) ? 1'b1 : (fire ? 1'b0 : req_full_ff);

   assign next_origin = (pos_ff == 8'hff) ? 8'hff : pos_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      origin_in = origin_ff;
      flags_in  = flags_ff;
      count_in  = count_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      err_in    = err_ff;
      pos_in    = (pos_ff == 8'hff) ? pos_ff : pos_ff + 8'd1;

      unique case (phase_ff)
         PH_HEAD: begin
            if (b == CHAR_COLON) begin
               // a head only matches at its exact length
               for (int k = 0; k < 3; k++) begin
                  if (count_ff != head_len(2'(k))) begin
                     flags_in[k] = 1'b0;
                  end
               end
               phase_in = PH_MAC;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  if (count_ff >= head_len(2'(k)) || head_char(2'(k), count_ff) != b) begin
                     flags_in[k] = 1'b0;
                  end
               end
               if (count_ff != 4'hf) begin
                  count_in = count_ff + 4'd1;
               end
            end
         end
         PH_MAC: begin
            if (b == CHAR_COMMA) begin
               origin_in = next_origin;
               if (flags_ff[HEAD_SETTIME]) begin
                  flags_in = 3'b001;
                  phase_in = PH_SET;
               end else if (flags_ff[HEAD_START]) begin
                  flags_in = 3'b010;
                  phase_in = PH_BEGIN;
               end else if (flags_ff[HEAD_READDATA]) begin
                  flags_in = 3'b100;
                  phase_in = PH_BEGIN;
               end else begin
                  err_in   = STATUS_UNKNOWN;
                  phase_in = PH_ERR;
               end
            end
         end
         PH_SET: begin
            t1_in = add_digit(t1_ff, b, pos_ff, origin_ff);
         end
         PH_BEGIN: begin
            if (b == CHAR_COMMA) begin
               origin_in = next_origin;
               phase_in  = PH_END;
            end else begin
               t1_in = add_digit(t1_ff, b, pos_ff, origin_ff);
            end
         end
         PH_END: begin
            t2_in = add_digit(t2_ff, b, pos_ff, origin_ff);
         end
         PH_ERR: begin
            // rest of the message is dropped
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // result of this byte, used only when it is the last one
      result.status       = STATUS_OK;
      result.command_kind = KIND_NONE;
      result.first_time   = '0;
      result.second_time  = '0;
      if (phase_ff == PH_HEAD && b != CHAR_COLON) begin
         result.status = STATUS_NO_COLON;
      end else if (phase_in == PH_ERR) begin
         result.status = err_in;
      end else if (phase_ff == PH_BEGIN) begin
         result.status       = STATUS_NO_END_TIME;
         result.command_kind = flags_in[HEAD_START] ? KIND_START : KIND_READDATA;
      end else if (phase_in == PH_SET) begin
         result.command_kind = KIND_SETTIME;
         if (phase_ff == PH_SET && date_bad(t1_in)) begin
            result.status = STATUS_BAD_DATE;
         end else begin
            result.first_time = t1_in;
         end
      end else if (phase_in == PH_BEGIN || phase_in == PH_END) begin
         result.command_kind = flags_in[HEAD_START] ? KIND_START : KIND_READDATA;
         result.first_time   = t1_in;
         result.second_time  = t2_in;
      end

      // every message starts from a clean parser
      if (last) begin
         phase_in  = PH_HEAD;
         pos_in    = 8'd0;
         origin_in = 8'd0;
         flags_in  = 3'b111;
         count_in  = 4'd0;
         t1_in     = '0;
         t2_in     = '0;
         err_in    = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff  <= 1'b0;
         phase_ff     <= PH_HEAD;
         pos_ff       <= 8'd0;
         origin_ff    <= 8'd0;
         flags_ff     <= 3'b111;
         count_ff     <= 4'd0;
         t1_ff        <= '0;
         t2_ff        <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
         if (fire) begin
            phase_ff  <= phase_in;
            pos_ff    <= pos_in;
            origin_ff <= origin_in;
            flags_ff  <= flags_in;
            count_ff  <= count_in;
            t1_ff     <= t1_in;
            t2_ff     <= t2_in;
            err_ff    <= err_in;
         end
         if (fire && last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_payload;
      end
      if (fire && last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule
